// ===== sv/mmbc_pkg.sv =====
// Shared types and constants for the merge marker balance checker.
package mmbc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int OUT_COUNT_BITS     = 16;
   localparam int PREFIX_LEN         = 7;
   localparam int COL_BITS           = $clog2(PREFIX_LEN + 1);
   localparam int QUEUE_DEPTH        = 4;
   localparam int NUM_KINDS          = 4;

   localparam logic [7:0] LINE_END  = 8'd10;
   localparam logic [7:0] TEXT_STOP = 8'd0;

   // marker kinds, in match priority order
   typedef enum logic [1:0] {
      MARK_OURS   = 2'd0,
      MARK_BASE   = 2'd1,
      MARK_SEP    = 2'd2,
      MARK_THEIRS = 2'd3
   } mark_kind_type;

   localparam logic [7:0] MARKER_CHAR [NUM_KINDS] = '{8'h3C, 8'h7C, 8'h3D, 8'h3E};

   // event passed from classifier to nesting checker
   typedef struct packed {
      logic          is_end;
      mark_kind_type kind;
   } ev_type;

endpackage

// ===== sv/mmbc_front.sv =====
// Line classifier: tracks column and marker candidates, emits marker and end events.
module mmbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   output logic                ev_push,
   output mmbc_pkg::ev_type    ev
);
   import mmbc_pkg::*;

   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [NUM_KINDS-1:0] mask_ff, mask_in;
   logic                 stopped_ff, stopped_in;
   logic [NUM_KINDS-1:0] match;

   always_comb begin
      for (int k = 0; k < NUM_KINDS; k++) begin
         match[k] = (req_text_byte == MARKER_CHAR[k]);
      end
   end

   always_comb begin
      col_in     = col_ff;
      mask_in    = mask_ff;
      stopped_in = stopped_ff;
      ev_push    = 1'b0;
      ev.is_end  = 1'b0;
      ev.kind    = MARK_OURS;
      if (req_valid && req_ready) begin
         if (req_end_of_text) begin
            ev_push    = 1'b1;
            ev.is_end  = 1'b1;
            col_in     = '0;
            mask_in    = '1;
            stopped_in = 1'b0;
         end else if (!stopped_ff) begin
            if (req_text_byte == TEXT_STOP) begin
               stopped_in = 1'b1;
            end else if (req_text_byte == LINE_END) begin
               col_in  = '0;
               mask_in = '1;
            end else if (col_ff < COL_BITS'(PREFIX_LEN)) begin
               mask_in = mask_ff & match;
               col_in  = col_ff + COL_BITS'(1);
               // seventh byte: classify the line
               if (col_ff == COL_BITS'(PREFIX_LEN - 1) && (|mask_in)) begin
                  ev_push = 1'b1;
                  for (int k = NUM_KINDS - 1; k >= 0; k--) begin
                     if (mask_in[k]) begin
                        ev.kind = mark_kind_type'(2'(k));
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         mask_ff    <= '1;
         stopped_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         mask_ff    <= mask_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== sv/mmbc_queue.sv =====
// Small event FIFO between classifier and nesting checker.
module mmbc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mmbc_pkg::ev_type    push_ev,
   input  logic                pop,
   output logic                head_valid,
   output mmbc_pkg::ev_type    head_ev,
   output logic                full
);
   import mmbc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   ev_type              mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_ev    = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + PTR_BITS'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_BITS'(1);
            2'b01:   count_ff <= count_ff - CNT_BITS'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== sv/mmbc_back.sv =====
// Nesting checker: order state machine, conflict counter, result register.
module mmbc_back #(
   parameter int COUNT_BITS = mmbc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  mmbc_pkg::ev_type    head_ev,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_balanced,
   output logic [15:0]         rsp_conflict_count,
   output logic                rsp_count_valid
);
   import mmbc_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   typedef enum logic [1:0] {
      NEST_OUT   = 2'd0,
      NEST_OURS  = 2'd1,
      NEST_BASE  = 2'd2,
      NEST_SEP   = 2'd3
   } nest_type;

   nest_type                state_ff;
   logic [COUNT_BITS-1:0]   cnt_ff;
   logic                    violation_ff;
   logic                    rsp_valid_ff;
   logic                    balanced_ff;
   logic [OUT_COUNT_BITS-1:0] count_out_ff;
   logic                    count_valid_ff;
   logic                    end_pop;
   logic [WIDE_BITS-1:0]    cnt_wide;
   logic [OUT_COUNT_BITS-1:0] cnt_sat;

   // marker events never wait; an end event waits for a free result slot
   assign pop     = head_valid && (!head_ev.is_end || !rsp_valid_ff || rsp_ready);
   assign end_pop = pop && head_ev.is_end;

   assign cnt_wide = WIDE_BITS'(cnt_ff);
   always_comb begin
      if ((cnt_wide >> OUT_COUNT_BITS) != '0) begin
         cnt_sat = '1;
      end else begin
         cnt_sat = cnt_wide[OUT_COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= NEST_OUT;
         cnt_ff       <= '0;
         violation_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (end_pop) begin
            rsp_valid_ff   <= 1'b1;
            balanced_ff    <= !violation_ff && (state_ff == NEST_OUT);
            count_out_ff   <= violation_ff ? '0 : cnt_sat;
            count_valid_ff <= !violation_ff;
            state_ff       <= NEST_OUT;
            cnt_ff         <= '0;
            violation_ff   <= 1'b0;
         end else begin
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
            if (pop && !violation_ff) begin
               case (head_ev.kind)
                  MARK_OURS: begin
                     if (state_ff != NEST_OUT) begin
                        violation_ff <= 1'b1;
                     end else begin
                        state_ff <= NEST_OURS;
                        if (cnt_ff != '1) begin
                           cnt_ff <= cnt_ff + COUNT_BITS'(1);
                        end
                     end
                  end
                  MARK_BASE: begin
                     if (state_ff != NEST_OURS) begin
                        violation_ff <= 1'b1;
                     end else begin
                        state_ff <= NEST_BASE;
                     end
                  end
                  MARK_SEP: begin
                     if (state_ff != NEST_OURS && state_ff != NEST_BASE) begin
                        violation_ff <= 1'b1;
                     end else begin
                        state_ff <= NEST_SEP;
                     end
                  end
                  default: begin
                     if (state_ff != NEST_SEP) begin
                        violation_ff <= 1'b1;
                     end else begin
                        state_ff <= NEST_OUT;
                     end
                  end
               endcase
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_balanced       = balanced_ff;
   assign rsp_conflict_count = count_out_ff;
   assign rsp_count_valid    = count_valid_ff;

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      end_pop |=> rsp_valid_ff)
      else $error("end event popped but no result registered");

   a_violation_sticky: assert property (@(posedge clock) disable iff (reset)
      (violation_ff && !end_pop) |=> violation_ff)
      else $error("violation flag cleared before end of text");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(end_pop)) |-> (cnt_ff >= $past(cnt_ff)))
      else $error("conflict counter went down without end of text");

   a_end_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      end_pop |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while still pending");

endmodule

// ===== sv/merge_marker_balance_checker.sv =====
// Top level of the merge marker balance checker: classifier, event queue, nesting checker.
//
// Usage:
//   Input channel (req_): one text byte per transaction. req_end_of_text = 1 marks an
//   end transaction; its byte is ignored and it yields exactly one result. Byte 10
//   ends a line, byte 0 ends the text (later bytes are ignored until the end item).
//   Result channel (rsp_): balanced, conflict_count (saturating at 65535) and
//   count_valid; when an order violation occurred, count and flags read zero.
// Throughput: one input transaction per cycle. The classifier pushes at most one event
//   per byte into a 4-entry queue; the nesting checker drains one event per cycle
//   unless an end event waits on a pending result, so req_ready drops only when the
//   queue is full. Path: an accepted end transaction is written to the queue and,
//   once the events queued ahead of it have drained and the result slot is free,
//   moves from the queue head into the result register.
// Receiver stall: the result register holds while rsp_ready is low; marker events keep
//   draining, a second end event waits in the queue, and input backs up only once
//   the queue fills.
// Reset: synchronous, active high; clears the scan, nesting state, counter, violation
//   flag, queue and pending result. No clearing pass is needed.
module merge_marker_balance_checker #(
   parameter int COUNT_BITS = mmbc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_balanced,
   output logic [15:0] rsp_conflict_count,
   output logic        rsp_count_valid
);
   import mmbc_pkg::*;

   logic   ev_push;
   ev_type ev;
   logic   q_full;
   logic   head_valid;
   ev_type head_ev;
   logic   pop;

   // stall the text only when the event queue has no room
   assign req_ready = !q_full;

   mmbc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .ev_push         (ev_push),
      .ev              (ev)
   );

   mmbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ev_push),
      .push_ev    (ev),
      .pop        (pop),
      .head_valid (head_valid),
      .head_ev    (head_ev),
      .full       (q_full)
   );

   mmbc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_ev            (head_ev),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_balanced       (rsp_balanced),
      .rsp_conflict_count (rsp_conflict_count),
      .rsp_count_valid    (rsp_count_valid)
   );

endmodule
